// ===== design/spc_pkg.sv =====
package spc_pkg;

    localparam int NUM_SENSORS_DEF = 2;
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);

    localparam logic [31:0] MIN_GAP_US = 32'd100000;
    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [41:0] TERM_CAP   = 42'h100_0000_0000;

    localparam logic [7:0] CFG_STRIPE_DISTANCE = 8'd0;
    localparam logic [7:0] CFG_MIN_UNCERTAINTY = 8'd1;
    localparam logic [7:0] CFG_MAX_STRIPE_LEAD = 8'd2;
    localparam logic [7:0] CFG_START_TIME      = 8'd3;

    localparam logic [30:0] DIST_RESET = 31'd1997537;
    localparam logic [30:0] MINU_RESET = 31'd3277;
    localparam logic [3:0]  LEAD_RESET = 4'd3;

    // classified item handed from front to back
    typedef struct packed {
        logic [31:0] disp;
        logic [31:0] vel;
        logic [30:0] dunc;
        logic [30:0] vunc;
        logic        seen;
        logic [31:0] elapsed;
    } job_t;

    typedef struct packed {
        logic [30:0] spacing;
        logic [30:0] minu;
        logic [3:0]  lead;
        logic [31:0] start;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [31:0] rem;
        logic [41:0] dv;
        logic [5:0]  steps;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [41:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL1, B_OFF1, B_COND, B_MUL2, B_OFF2, B_MISS, B_MISSW,
        B_RMLO, B_RMHI, B_RSUM, B_RDIV, B_RWAIT, B_FIN, B_LEAD
    } back_state_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [47:0] mag50(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = v[49] ? -v : v;
        return t[47:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -51'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

endpackage

// ===== design/stripe_position_corrector.sv =====
// Stripe position corrector.
// Input words (s_axis_*) carry both stripe sensor counts and timestamps plus
// the inertial displacement, velocity and uncertainties; s_axis_tuser marks
// simulated timing. Each word yields exactly one result word on m_axis_*.
// Registers are written on the cfg_* channel (always ready); the user must
// write them only while idle, which the block does not enforce. The front
// classifies a word in the cycle it arrives (which sensor, if any, saw a
// stripe) and pushes it into a two-word queue; it keeps accepting as long as
// the queue has room. The back works on one word at a time; when a stripe is
// seen, its result waits on the bit-serial divider, which spends 8 steps on
// the missed count and 42 steps on each of the two velocity terms. The back
// takes the next word the cycle after a result leaves. Result words sit in an
// output register; while the receiver stalls the back starts no further word,
// the queue fills and s_axis_tready drops.
// Reset clears the counters, last counts, last stripe time, queue and output
// valid, and restores the register defaults.
module stripe_position_corrector #(
    parameter int NUM_SENSORS = spc_pkg::NUM_SENSORS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sensor_a_count, sensor_a_time, sensor_b_count, sensor_b_time,
    // imu_displacement, imu_velocity, disp_uncertainty, vel_uncertainty, now_time
    input  logic [255:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,   // simulated
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // displacement_out, velocity_out, vel_uncertainty_out, stripes_counted,
    // missed_total
    output logic [119:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // stripe_seen, failure
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    spc_pkg::cfg_t     cfg_reg;
    spc_pkg::job_t     fr_job, q_job;
    spc_pkg::div_req_t div_req;
    spc_pkg::div_rsp_t div_rsp;
    logic              push, pop, full, empty;
    logic [31:0]       disp_o, vel_o;
    logic [30:0]       vunc_o;
    logic [15:0]       stot_o;
    logic [7:0]        miss_o;
    logic              seen_o, fail_o;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spacing <= spc_pkg::DIST_RESET;
            cfg_reg.minu    <= spc_pkg::MINU_RESET;
            cfg_reg.lead    <= spc_pkg::LEAD_RESET;
            cfg_reg.start   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                spc_pkg::CFG_STRIPE_DISTANCE: cfg_reg.spacing <= cfg_data[30:0];
                spc_pkg::CFG_MIN_UNCERTAINTY: cfg_reg.minu    <= cfg_data[30:0];
                spc_pkg::CFG_MAX_STRIPE_LEAD: cfg_reg.lead    <= cfg_data[3:0];
                spc_pkg::CFG_START_TIME:      cfg_reg.start   <= cfg_data;
                default: ;
            endcase
        end
    end

    spc_front #(.NUM_SENSORS(NUM_SENSORS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .cnt_a      (s_axis_tdata[15:0]),
        .tim_a      (s_axis_tdata[47:16]),
        .cnt_b      (s_axis_tdata[63:48]),
        .tim_b      (s_axis_tdata[95:64]),
        .disp       (s_axis_tdata[127:96]),
        .vel        (s_axis_tdata[159:128]),
        .dunc       (s_axis_tdata[190:160]),
        .vunc       (s_axis_tdata[221:191]),
        .sim        (s_axis_tuser[0]),
        .now        (s_axis_tdata[253:222]),
        .start_time (cfg_reg.start),
        .full       (full),
        .push       (push),
        .job        (fr_job)
    );

    spc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (fr_job),
        .pop     (pop),
        .rd_data (q_job),
        .full    (full),
        .empty   (empty)
    );

    spc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    spc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_empty     (empty),
        .q_data      (q_job),
        .q_pop       (pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .disp_out    (disp_o),
        .vel_out     (vel_o),
        .vunc_out    (vunc_o),
        .stripes_out (stot_o),
        .missed_out  (miss_o),
        .seen_out    (seen_o),
        .fail_out    (fail_o)
    );

    assign m_axis_tdata = {1'b0, miss_o, stot_o, vunc_o, vel_o, disp_o};
    assign m_axis_tuser = {fail_o, seen_o};

    a_fail_on_missed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[118:111] > 8'd1) |-> m_axis_tuser[1])
        else $error("failure not flagged with missed count above one");

    a_seen_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[110:95] != 16'd0))
        else $error("stripe seen with zero stripe total");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

// ===== design/spc_fifo.sv =====
module spc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  spc_pkg::job_t wr_data,
    input  logic          pop,
    output spc_pkg::job_t rd_data,
    output logic          full,
    output logic          empty
);
    spc_pkg::job_t mem [spc_pkg::QDEPTH];
    logic [spc_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [spc_pkg::QAW:0]   cnt_reg;

    assign full    = (cnt_reg == (spc_pkg::QAW+1)'(spc_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

// ===== design/spc_front.sv =====
module spc_front #(
    parameter int NUM_SENSORS = spc_pkg::NUM_SENSORS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   cnt_a,
    input  logic [31:0]   tim_a,
    input  logic [15:0]   cnt_b,
    input  logic [31:0]   tim_b,
    input  logic [31:0]   disp,
    input  logic [31:0]   vel,
    input  logic [30:0]   dunc,
    input  logic [30:0]   vunc,
    input  logic          sim,
    input  logic [31:0]   now,
    input  logic [31:0]   start_time,
    input  logic          full,
    output logic          push,
    output spc_pkg::job_t job
);
    localparam int NS_USED = (NUM_SENSORS < 2) ? NUM_SENSORS : 2;

    logic [15:0] cnt_in [2];
    logic [31:0] tim_in [2];
    logic [15:0] last_cnt_reg [2];
    logic [31:0] lst_reg;
    logic        hit;
    logic        sel;
    logic [31:0] new_lst;

    assign cnt_in[0] = cnt_a;
    assign cnt_in[1] = cnt_b;
    assign tim_in[0] = tim_a;
    assign tim_in[1] = tim_b;

    // first sensor (a before b) with a new count and enough gap wins
    always_comb begin
        hit = 1'b0;
        sel = 1'b0;
        for (int i = 0; i < NS_USED; i++) begin
            if (!hit && cnt_in[i] != last_cnt_reg[i] &&
                (tim_in[i] - lst_reg) >= spc_pkg::MIN_GAP_US) begin
                hit = 1'b1;
                sel = i[0];
            end
        end
    end

    assign new_lst  = sim ? now : tim_in[sel];
    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb begin
        job.disp    = disp;
        job.vel     = vel;
        job.dunc    = dunc;
        job.vunc    = vunc;
        job.seen    = hit;
        job.elapsed = new_lst - start_time;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cnt_reg[0] <= '0;
            last_cnt_reg[1] <= '0;
            lst_reg         <= '0;
        end else if (push) begin
            last_cnt_reg[0] <= cnt_a;
            last_cnt_reg[1] <= cnt_b;
            if (hit) lst_reg <= new_lst;
        end
    end
endmodule

// ===== design/spc_div.sv =====
module spc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  spc_pkg::div_req_t req,
    output spc_pkg::div_rsp_t rsp
);
    logic [31:0] rem_reg;
    logic [41:0] dv_reg;
    logic [41:0] q_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] d_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] sh;
    logic        ge;

    // restoring division, one quotient bit per cycle
    assign sh = {rem_reg, dv_reg[41]};
    assign ge = (sh >= {1'b0, d_reg});

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem;
            dv_reg  <= req.dv;
            d_reg   <= req.divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? 32'(sh - {1'b0, d_reg}) : sh[31:0];
            dv_reg  <= {dv_reg[40:0], 1'b0};
            q_reg   <= {q_reg[40:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== design/spc_back.sv =====
module spc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  spc_pkg::cfg_t     cfg,
    input  logic              q_empty,
    input  spc_pkg::job_t     q_data,
    output logic              q_pop,
    output spc_pkg::div_req_t div_req,
    input  spc_pkg::div_rsp_t div_rsp,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       disp_out,
    output logic [31:0]       vel_out,
    output logic [30:0]       vunc_out,
    output logic [15:0]       stripes_out,
    output logic [7:0]        missed_out,
    output logic              seen_out,
    output logic              fail_out
);
    spc_pkg::back_state_t state_reg, state_next;

    spc_pkg::job_t      job_reg;
    logic [15:0]        stot_reg;
    logic [7:0]         miss_reg;
    logic [46:0]        prod_reg;
    logic [34:0]        lead_reg;
    logic signed [49:0] off_reg, offa_reg, off2_reg;
    logic [30:0]        allow_reg;
    logic               pass_reg;
    logic               neg_reg;
    logic [47:0]        mag_reg;
    logic [43:0]        plo_reg, phi_reg;
    logic [67:0]        num_reg;
    logic signed [41:0] term1_reg, term2_reg;
    logic [31:0]        dispf_reg, velf_reg;
    logic [30:0]        vuncf_reg;

    logic               ov_reg;
    logic [31:0]        o_disp_reg, o_vel_reg;
    logic [30:0]        o_vunc_reg;
    logic [15:0]        o_stot_reg;
    logic [7:0]         o_miss_reg;
    logic               o_seen_reg, o_fail_reg;

    logic [47:0]        mag_a;
    logic               miss_big;
    logic               miss_sat;
    logic               need_div;
    logic               no_time;
    logic               rsat;
    logic               start_item;
    logic [47:0]        msel;
    logic               cond;
    logic signed [50:0] lo, hi, two_off;
    logic [41:0]        res;
    logic signed [41:0] term_new;
    logic [9:0]         miss_sum;
    logic [40:0]        t1m;
    logic signed [42:0] vd;
    logic [42:0]        vdm;
    logic signed [50:0] vel_d, disp_d, lead_d;

    assign start_item = !q_empty && !ov_reg;
    assign mag_a      = spc_pkg::mag50(offa_reg);
    assign miss_big   = mag_a > {16'b0, allow_reg, 1'b0};
    // quotient of 256 or more saturates the count anyway
    assign miss_sat   = (cfg.spacing == '0) || (mag_a[47:8] >= {9'b0, cfg.spacing});
    assign need_div   = miss_big && !miss_sat;
    assign no_time    = (job_reg.elapsed == '0);
    assign rsat       = ({6'b0, num_reg[67:42]} >= job_reg.elapsed);
    assign msel       = pass_reg ? spc_pkg::mag50(off2_reg) : mag_a;

    always_comb begin
        lo      = $signed({20'b0, cfg.spacing}) - $signed({20'b0, allow_reg});
        hi      = $signed({20'b0, cfg.spacing}) + $signed({20'b0, allow_reg});
        two_off = {off_reg, 1'b0};
        cond    = ($signed({off_reg[49], off_reg}) > lo) &&
                  ($signed({off_reg[49], off_reg}) < hi) &&
                  (two_off > $signed({20'b0, cfg.spacing}));
    end

    always_comb begin
        res      = (div_rsp.quot > spc_pkg::TERM_CAP) ? spc_pkg::TERM_CAP : div_rsp.quot;
        term_new = neg_reg ? -$signed(res) : $signed(res);
        miss_sum = {2'b0, miss_reg} + 10'd1 + {2'b0, div_rsp.quot[7:0]};
    end

    always_comb begin
        t1m    = term1_reg[41] ? 41'(-term1_reg) : term1_reg[40:0];
        vd     = $signed({12'b0, job_reg.vunc}) - $signed({2'b0, t1m});
        vdm    = vd[42] ? 43'(-vd) : 43'(vd);
        vel_d  = $signed({{19{job_reg.vel[31]}}, job_reg.vel}) -
                 $signed({{9{term2_reg[41]}}, term2_reg});
        disp_d = $signed({{19{job_reg.disp[31]}}, job_reg.disp}) -
                 $signed({off2_reg[49], off2_reg});
        lead_d = $signed({{19{dispf_reg[31]}}, dispf_reg}) - $signed({4'b0, prod_reg});
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spc_pkg::B_IDLE:
                if (start_item) state_next = q_data.seen ? spc_pkg::B_MUL1 : spc_pkg::B_MUL2;
            spc_pkg::B_MUL1: state_next = spc_pkg::B_OFF1;
            spc_pkg::B_OFF1: state_next = spc_pkg::B_COND;
            spc_pkg::B_COND: state_next = spc_pkg::B_MUL2;
            spc_pkg::B_MUL2: state_next = spc_pkg::B_OFF2;
            spc_pkg::B_OFF2:
                state_next = job_reg.seen ? spc_pkg::B_MISS : spc_pkg::B_FIN;
            spc_pkg::B_MISS:
                if (need_div) state_next = spc_pkg::B_MISSW;
                else state_next = no_time ? spc_pkg::B_FIN : spc_pkg::B_RMLO;
            spc_pkg::B_MISSW:
                if (div_rsp.done) state_next = no_time ? spc_pkg::B_FIN : spc_pkg::B_RMLO;
            spc_pkg::B_RMLO: state_next = spc_pkg::B_RMHI;
            spc_pkg::B_RMHI: state_next = spc_pkg::B_RSUM;
            spc_pkg::B_RSUM: state_next = spc_pkg::B_RDIV;
            spc_pkg::B_RDIV:
                if (rsat) state_next = pass_reg ? spc_pkg::B_FIN : spc_pkg::B_RMLO;
                else state_next = spc_pkg::B_RWAIT;
            spc_pkg::B_RWAIT:
                if (div_rsp.done) state_next = pass_reg ? spc_pkg::B_FIN : spc_pkg::B_RMLO;
            spc_pkg::B_FIN:  state_next = spc_pkg::B_LEAD;
            spc_pkg::B_LEAD: state_next = spc_pkg::B_IDLE;
            default:         state_next = spc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_pop           = 1'b0;
        div_req.start   = 1'b0;
        div_req.rem     = {6'b0, num_reg[67:42]};
        div_req.dv      = num_reg[41:0];
        div_req.steps   = 6'd42;
        div_req.divisor = job_reg.elapsed;
        unique case (state_reg)
            spc_pkg::B_IDLE: q_pop = start_item;
            spc_pkg::B_MISS: begin
                div_req.start   = need_div;
                div_req.rem     = {1'b0, mag_a[38:8]};
                div_req.dv      = {mag_a[7:0], 34'b0};
                div_req.steps   = 6'd8;
                div_req.divisor = {1'b0, cfg.spacing};
            end
            spc_pkg::B_RDIV: div_req.start = !rsat;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            spc_pkg::B_IDLE: begin
                if (start_item) begin
                    job_reg   <= q_data;
                    pass_reg  <= 1'b0;
                    term1_reg <= '0;
                    term2_reg <= '0;
                end
            end
            spc_pkg::B_MUL1: prod_reg <= 47'(spc_pkg::sat_inc16(stot_reg) * cfg.spacing);
            spc_pkg::B_OFF1: begin
                off_reg   <= $signed({{18{job_reg.disp[31]}}, job_reg.disp}) -
                             $signed({3'b0, prod_reg});
                allow_reg <= (job_reg.dunc > cfg.minu) ? job_reg.dunc : cfg.minu;
            end
            spc_pkg::B_COND:
                offa_reg <= cond ? off_reg - $signed({19'b0, cfg.spacing}) : off_reg;
            spc_pkg::B_MUL2: begin
                prod_reg <= 47'(stot_reg * cfg.spacing);
                lead_reg <= 35'(cfg.lead * cfg.spacing);
            end
            spc_pkg::B_OFF2:
                off2_reg <= $signed({{18{job_reg.disp[31]}}, job_reg.disp}) -
                            $signed({3'b0, prod_reg});
            spc_pkg::B_RMLO: begin
                mag_reg <= msel;
                neg_reg <= pass_reg ? off2_reg[49] : offa_reg[49];
                plo_reg <= 44'(msel[23:0] * spc_pkg::US_PER_S);
            end
            spc_pkg::B_RMHI: phi_reg <= 44'(mag_reg[47:24] * spc_pkg::US_PER_S);
            spc_pkg::B_RSUM: num_reg <= {phi_reg, 24'b0} + {24'b0, plo_reg};
            spc_pkg::B_RDIV: begin
                if (rsat) begin
                    if (pass_reg) term2_reg <= neg_reg ? -$signed(spc_pkg::TERM_CAP)
                                                       : $signed(spc_pkg::TERM_CAP);
                    else term1_reg <= neg_reg ? -$signed(spc_pkg::TERM_CAP)
                                              : $signed(spc_pkg::TERM_CAP);
                    pass_reg <= 1'b1;
                end
            end
            spc_pkg::B_RWAIT: begin
                if (div_rsp.done) begin
                    if (pass_reg) term2_reg <= term_new;
                    else term1_reg <= term_new;
                    pass_reg <= 1'b1;
                end
            end
            spc_pkg::B_FIN: begin
                if (job_reg.seen) begin
                    vuncf_reg <= (vdm > 43'h7FFF_FFFF) ? 31'h7FFF_FFFF : vdm[30:0];
                    velf_reg  <= spc_pkg::sat32(vel_d);
                    dispf_reg <= spc_pkg::sat32(disp_d);
                end else begin
                    vuncf_reg <= job_reg.vunc;
                    velf_reg  <= job_reg.vel;
                    dispf_reg <= job_reg.disp;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == spc_pkg::B_LEAD) begin
            o_disp_reg <= dispf_reg;
            o_vel_reg  <= velf_reg;
            o_vunc_reg <= vuncf_reg;
            o_stot_reg <= stot_reg;
            o_miss_reg <= miss_reg;
            o_seen_reg <= job_reg.seen;
            o_fail_reg <= (miss_reg > 8'd1) || (lead_d > $signed({16'b0, lead_reg}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spc_pkg::B_IDLE;
            stot_reg  <= '0;
            miss_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == spc_pkg::B_MUL1) stot_reg <= spc_pkg::sat_inc16(stot_reg);
            if (state_reg == spc_pkg::B_COND && cond) stot_reg <= spc_pkg::sat_inc16(stot_reg);
            if (state_reg == spc_pkg::B_MISS && miss_big && miss_sat) miss_reg <= 8'hFF;
            if (state_reg == spc_pkg::B_MISSW && div_rsp.done)
                miss_reg <= (miss_sum > 10'd255) ? 8'hFF : miss_sum[7:0];
            if (state_reg == spc_pkg::B_LEAD) ov_reg <= 1'b1;
            else if (ov_reg && out_ready) ov_reg <= 1'b0;
        end
    end

    assign out_valid   = ov_reg;
    assign disp_out    = o_disp_reg;
    assign vel_out     = o_vel_reg;
    assign vunc_out    = o_vunc_reg;
    assign stripes_out = o_stot_reg;
    assign missed_out  = o_miss_reg;
    assign seen_out    = o_seen_reg;
    assign fail_out    = o_fail_reg;
endmodule
